>>> hw/rtl/bprs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bprs_pkg
// Shared types and constants for the breathing ramp sequencer.
// ----------------------------------------------------------------------------
package bprs_pkg;

   localparam int DutyWidth  = 16;
   localparam int StepsWidth = 8;
   localparam int HoldWidth  = 15;
   localparam int CsrIdxWidth  = 3;
   localparam int CsrDataWidth = 16;

   localparam logic [HoldWidth-1:0] HoldMax = {HoldWidth{1'b1}};

   // register indexes of the configuration port
   localparam logic [CsrIdxWidth-1:0] CsrDutyTarget  = 3'd0;
   localparam logic [CsrIdxWidth-1:0] CsrDutyMinimum = 3'd1;
   localparam logic [CsrIdxWidth-1:0] CsrRampSteps   = 3'd2;
   localparam logic [CsrIdxWidth-1:0] CsrHoldBright  = 3'd3;
   localparam logic [CsrIdxWidth-1:0] CsrHoldDull    = 3'd4;

   localparam logic [StepsWidth-1:0] RampStepsReset = 8'd4;

   typedef enum logic [2:0] {
      PH_RAMP_ON   = 3'd0,
      PH_RAMP_UP   = 3'd1,
      PH_ON        = 3'd2,
      PH_HOLD_BRT  = 3'd3,
      PH_RAMP_OFF  = 3'd4,
      PH_RAMP_DOWN = 3'd5,
      PH_OFF       = 3'd6,
      PH_HOLD_DULL = 3'd7
   } phase_type;

   typedef struct packed {
      logic [DutyWidth-1:0]  duty_target;
      logic [DutyWidth-1:0]  duty_minimum;
      logic [StepsWidth-1:0] ramp_steps;
      logic [HoldWidth-1:0]  hold_bright_ticks;
      logic [HoldWidth-1:0]  hold_dull_ticks;
   } cfg_type;

endpackage

>>> hw/rtl/pwm_breathing_ramp_sequencer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pwm_breathing_ramp_sequencer
// Breathing PWM sequencer: one tick beat in, one compare/enable/phase beat out.
// Path: an accepted tick is held in the input register; the combinational phase
// logic then loads the state/result registers once the result register drains.
// Throughput: 1 tick per cycle; limited only by the result register draining.
// Reset: synchronous, active high; clears both stages, phase goes to off and
// the configuration registers return to their defaults.
// ----------------------------------------------------------------------------
module pwm_breathing_ramp_sequencer
   import bprs_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   input  logic [7:0]              req_tdata,   // [0] pwm_enable, [7:1] zero
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   output logic [23:0]             rsp_tdata,   // [15:0] compare_value, [16] output_on,
                                                // [19:17] phase, [23:20] zero
   input  logic                    csr_we,
   input  logic [CsrIdxWidth-1:0]  csr_index,
   input  logic [CsrDataWidth-1:0] csr_wdata
);

   cfg_type              cfg;
   logic                 in_valid_ff, in_valid_in;
   logic                 in_en_ff;
   logic                 out_valid_ff, out_valid_in;
   logic                 advance;
   logic                 req_fire;
   logic [DutyWidth-1:0] compare_value;
   logic                 output_on;
   phase_type            phase;

   // result register doubles as the sequencer state, so a tick only steps
   // once the previous result has left
   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign req_fire   = req_tvalid && req_tready;

   assign in_valid_in  = req_fire || (in_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_en_ff <= req_tdata[0];
      end
   end

   bprs_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   bprs_core u_core (
      .clock         (clock),
      .reset         (reset),
      .step_en       (advance),
      .pwm_enable    (in_en_ff),
      .cfg           (cfg),
      .compare_value (compare_value),
      .output_on     (output_on),
      .phase         (phase)
   );

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {4'b0000, phase, output_on, compare_value};

endmodule

>>> hw/rtl/bprs_csr.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bprs_csr
// Configuration register file, write only.
// ----------------------------------------------------------------------------
module bprs_csr
   import bprs_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    csr_we,
   input  logic [CsrIdxWidth-1:0]  csr_index,
   input  logic [CsrDataWidth-1:0] csr_wdata,
   output cfg_type                 cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            CsrDutyTarget:  cfg_in.duty_target       = csr_wdata;
            CsrDutyMinimum: cfg_in.duty_minimum      = csr_wdata;
            CsrRampSteps:   cfg_in.ramp_steps        = csr_wdata[StepsWidth-1:0];
            CsrHoldBright:  cfg_in.hold_bright_ticks = csr_wdata[HoldWidth-1:0];
            CsrHoldDull:    cfg_in.hold_dull_ticks   = csr_wdata[HoldWidth-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.duty_target       <= '0;
         cfg_ff.duty_minimum      <= '0;
         cfg_ff.ramp_steps        <= RampStepsReset;
         cfg_ff.hold_bright_ticks <= '0;
         cfg_ff.hold_dull_ticks   <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

>>> hw/rtl/bprs_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bprs_core
// Phase sequencer and level datapath; one tick per step enable.
// ----------------------------------------------------------------------------
module bprs_core
   import bprs_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 step_en,
   input  logic                 pwm_enable,
   input  cfg_type              cfg,
   output logic [DutyWidth-1:0] compare_value,
   output logic                 output_on,
   output phase_type            phase
);

   phase_type             phase_ff, phase_in;
   logic [DutyWidth-1:0]  level_ff, level_in;
   logic [DutyWidth-1:0]  step_ff, step_in;
   logic [StepsWidth-1:0] cnt_ff, cnt_in;
   logic [HoldWidth-1:0]  hold_ff, hold_in;
   logic [DutyWidth-1:0]  cmp_ff, cmp_in;
   logic                  on_ff, on_in;

   logic [DutyWidth:0]    up_sum;
   logic [DutyWidth-1:0]  up_sat;
   logic                  up_more;
   logic                  down_more;
   logic [HoldWidth-1:0]  hold_thr;
   logic                  hold_over;
   logic [HoldWidth-1:0]  hold_tick;

   assign up_sum    = {1'b0, level_ff} + {1'b0, step_ff};
   assign up_sat    = up_sum[DutyWidth] ? {DutyWidth{1'b1}} : up_sum[DutyWidth-1:0];
   assign up_more   = cnt_ff < cfg.ramp_steps;
   assign down_more = ({1'b0, cnt_ff} + 9'd1) < {1'b0, cfg.ramp_steps};
   assign hold_thr  = (phase_ff == PH_HOLD_BRT) ? cfg.hold_bright_ticks
                                                : cfg.hold_dull_ticks;
   assign hold_over = hold_ff > hold_thr;
   // hold count sticks at its top value
   assign hold_tick = hold_over ? '0 :
                      (hold_ff == HoldMax) ? hold_ff : hold_ff + 1'b1;

   // next phase
   always_comb begin
      phase_in = phase_ff;
      if (!pwm_enable) begin
         phase_in = PH_RAMP_ON;
      end else begin
         unique case (phase_ff)
            PH_RAMP_ON:   phase_in = PH_RAMP_UP;
            PH_RAMP_UP:   phase_in = up_more ? PH_RAMP_UP : PH_ON;
            PH_ON:        phase_in = PH_HOLD_BRT;
            PH_HOLD_BRT:  phase_in = hold_over ? PH_RAMP_OFF : PH_HOLD_BRT;
            PH_RAMP_OFF:  phase_in = PH_RAMP_DOWN;
            PH_RAMP_DOWN: phase_in = down_more ? PH_RAMP_DOWN : PH_OFF;
            PH_OFF:       phase_in = PH_HOLD_DULL;
            PH_HOLD_DULL: phase_in = hold_over ? PH_RAMP_ON : PH_HOLD_DULL;
            default:      phase_in = PH_RAMP_ON;
         endcase
      end
   end

   // datapath and outputs
   always_comb begin
      level_in = level_ff;
      step_in  = step_ff;
      cnt_in   = cnt_ff;
      hold_in  = hold_ff;
      cmp_in   = cmp_ff;
      on_in    = on_ff;
      if (!pwm_enable) begin
         cmp_in = '0;
         on_in  = 1'b0;
      end else begin
         unique case (phase_ff)
            PH_RAMP_ON: begin
               cmp_in   = cfg.duty_minimum;
               on_in    = 1'b1;
               level_in = '0;
               step_in  = cfg.duty_target >> 2;
               cnt_in   = '0;
            end
            PH_RAMP_UP: begin
               if (up_more) begin
                  cnt_in   = cnt_ff + 1'b1;
                  level_in = (level_ff < cfg.duty_target) ? up_sat : cfg.duty_target;
               end else begin
                  level_in = cfg.duty_target;
               end
               cmp_in = level_in;
            end
            PH_ON: begin
               cmp_in  = level_ff;
               hold_in = '0;
            end
            PH_HOLD_BRT, PH_HOLD_DULL: begin
               hold_in = hold_tick;
            end
            PH_RAMP_OFF: begin
               level_in = cfg.duty_target;
               step_in  = cfg.duty_target >> 2;
               cnt_in   = '0;
            end
            PH_RAMP_DOWN: begin
               if (down_more) begin
                  cnt_in = cnt_ff + 1'b1;
                  if (level_ff > step_ff) begin
                     level_in = level_ff - step_ff;
                  end
               end else begin
                  level_in = cfg.duty_minimum;
               end
               cmp_in = level_in;
            end
            PH_OFF: begin
               cmp_in  = '0;
               on_in   = 1'b0;
               hold_in = '0;
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_OFF;
         level_ff <= '0;
         step_ff  <= '0;
         cnt_ff   <= '0;
         hold_ff  <= '0;
         cmp_ff   <= '0;
         on_ff    <= 1'b0;
      end else if (step_en) begin
         phase_ff <= phase_in;
         level_ff <= level_in;
         step_ff  <= step_in;
         cnt_ff   <= cnt_in;
         hold_ff  <= hold_in;
         cmp_ff   <= cmp_in;
         on_ff    <= on_in;
      end
   end

   assign compare_value = cmp_ff;
   assign output_on     = on_ff;
   assign phase         = phase_ff;

endmodule
